[hdl/swsd_pkg.sv]
package swsd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int SUM_W      = 25;
    localparam int SQ_W       = 39;
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NUM_W      = 47;
    localparam int DEN_W      = 17;
    localparam int ROOT_W     = 24;
    localparam int SUB_W      = 27;
    localparam int CFG_W      = 16;

    localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(16);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Operands for the shared multiplier and trial subtractor.
    typedef struct packed {
        logic [MUL_W-1:0] mul_a;
        logic [MUL_W-1:0] mul_b;
        logic [SUB_W-1:0] sub_a;
        logic [SUB_W-1:0] sub_b;
    } t_alu_req;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [SUB_W-1:0]  diff;
        logic              ge;
    } t_alu_rsp;

endpackage

[hdl/swsd_ring.sv]
module swsd_ring (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [swsd_pkg::PTR_W-1:0]      i_waddr,
    input  swsd_pkg::t_sample               i_wdata,
    input  logic                            i_re,
    input  logic [swsd_pkg::PTR_W-1:0]      i_raddr,
    output swsd_pkg::t_sample               o_rdata
);
    import swsd_pkg::*;

    t_sample r_mem [RING_DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/swsd_alu.sv]
module swsd_alu (
    input  logic                i_clk,
    input  swsd_pkg::t_alu_req  i_req,
    output swsd_pkg::t_alu_rsp  o_rsp
);
    import swsd_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [SUB_W:0]    w_diff;

    // The product is registered; the trial subtraction is combinational.
    always_ff @(posedge i_clk) begin
        r_prod <= i_req.mul_a * i_req.mul_b;
    end

    assign w_diff     = {1'b0, i_req.sub_a} - {1'b0, i_req.sub_b};
    assign o_rsp.prod = r_prod;
    assign o_rsp.diff = w_diff[SUB_W-1:0];
    assign o_rsp.ge   = ~w_diff[SUB_W];

endmodule

[hdl/sliding_window_std_dev_top.sv]
// Items are handled one at a time: a new item is accepted only in the idle state, after the
// previous result has gone into the output register. Each item passes through nine multiply,
// update and set-up steps, 47 restoring division steps and 24 square root steps sharing one
// trial subtractor, a step that loads the root and a step that hands over the result.
// Reset (i_rst_n low, synchronous) sets the window length to 16 and clears the write pointer,
// the fill count and both running sums; the sample ring itself is not cleared.
module sliding_window_std_dev_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata: sample [15:0].
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,
    // Result stream. tdata: std_dev [23:0].
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    // Configuration write. data: window_length [8:0], upper bits ignored.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import swsd_pkg::*;

    // The sequencer walks each item through the steps below. The early steps drive the
    // shared multiplier one operation at a time; its product is read in the following step.
    typedef enum logic [3:0] {
        S_IDLE,   // waiting for an item
        S_SQX,    // square the new sample, write it into the ring
        S_SQO,    // square the oldest sample, add the new one to the sums
        S_SSUM,   // remove the oldest square, square the running sum
        S_M2,     // keep sum squared, form m squared
        S_ML,     // keep the divisor, form m times the low part of the square sum
        S_MH,     // keep the low partial product, form the high one
        S_NUM,    // combine the partial products
        S_SUB,    // subtract the squared sum, clamping at zero
        S_DINIT,  // load the divider
        S_DIV,    // one quotient bit per cycle
        S_SINIT,  // load the square root
        S_SQRT,   // one root bit per cycle
        S_DONE    // hand the result to the output register
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_win;
    logic [PTR_W-1:0]   r_wp;
    logic [CNT_W-1:0]   r_fill;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]    r_sumsq;

    // Per-item working registers.
    t_sample            r_x;
    logic [PTR_W-1:0]   r_slot;
    logic               r_full;
    logic [NUM_W-1:0]   r_ssq;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_dq;
    logic [NUM_W:0]     r_sx;
    logic [ROOT_W:0]    r_sr;
    logic [ROOT_W-1:0]  r_root;
    logic [5:0]         r_cnt;

    logic               r_out_valid;
    logic [ROOT_W-1:0]  r_out_data;

    logic [CNT_W-1:0]   w_len;
    logic [PTR_W-1:0]   n_slot;
    logic [CNT_W-1:0]   n_wp;
    logic               w_in_acc;
    logic               w_cfg_acc;
    logic               w_out_free;
    t_sample            w_old;
    t_alu_req           w_req;
    t_alu_rsp           w_rsp;

    function automatic logic [SAMPLE_W-1:0] abs_sample(input t_sample v);
        logic [SAMPLE_W-1:0] neg;
        neg = SAMPLE_W'(-v);
        return v[SAMPLE_W-1] ? neg : SAMPLE_W'(v);
    endfunction

    function automatic logic [MUL_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] neg;
        neg = SUM_W'(-v);
        return v[SUM_W-1] ? neg[MUL_W-1:0] : v[MUL_W-1:0];
    endfunction

    // A window length of zero acts as one; lengths beyond the ring saturate at its depth.
    always_comb begin
        if (r_win == '0) begin
            w_len = CNT_W'(1);
        end else if (r_win > CNT_W'(RING_DEPTH)) begin
            w_len = CNT_W'(RING_DEPTH);
        end else begin
            w_len = r_win;
        end
    end

    // The pointer wraps at the current length, so a stale pointer falls back to slot zero.
    assign n_slot = ({1'b0, r_wp} >= w_len) ? '0 : r_wp;
    assign n_wp   = {1'b0, r_slot} + CNT_W'(1);

    // A configuration write takes priority over an item arriving in the same cycle.
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    swsd_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_SQX),
        .i_waddr (r_slot),
        .i_wdata (r_x),
        .i_re    (w_in_acc),
        .i_raddr (n_slot),
        .o_rdata (w_old)
    );

    // Operand selection for the shared multiplier and subtractor.
    always_comb begin
        w_req = '0;
        case (r_state)
            S_SQX: begin
                w_req.mul_a = MUL_W'(abs_sample(r_x));
                w_req.mul_b = MUL_W'(abs_sample(r_x));
            end
            S_SQO: begin
                w_req.mul_a = MUL_W'(abs_sample(w_old));
                w_req.mul_b = MUL_W'(abs_sample(w_old));
            end
            S_SSUM: begin
                w_req.mul_a = abs_sum(r_sum);
                w_req.mul_b = abs_sum(r_sum);
            end
            S_M2: begin
                w_req.mul_a = MUL_W'(r_fill);
                w_req.mul_b = MUL_W'(r_fill);
            end
            S_ML: begin
                w_req.mul_a = MUL_W'(r_fill);
                w_req.mul_b = MUL_W'(r_sumsq[19:0]);
            end
            S_MH: begin
                w_req.mul_a = MUL_W'(r_fill);
                w_req.mul_b = MUL_W'(r_sumsq[SQ_W-1:20]);
            end
            S_DIV: begin
                w_req.sub_a = SUB_W'({r_rem, r_dq[NUM_W-1]});
                w_req.sub_b = SUB_W'(r_den);
            end
            S_SQRT: begin
                w_req.sub_a = {r_sr, r_sx[NUM_W:NUM_W-1]};
                w_req.sub_b = SUB_W'({r_root, 2'b01});
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    swsd_alu u_alu (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WIN_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the hand-over step the output register is refilled below instead.
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cfg_acc) begin
                        // A new length restarts the statistics from an empty window.
                        r_win   <= i_cfg_data[CNT_W-1:0];
                        r_wp    <= '0;
                        r_fill  <= '0;
                        r_sum   <= '0;
                        r_sumsq <= '0;
                    end else if (w_in_acc) begin
                        r_x     <= t_sample'(i_s_axis_tdata);
                        r_slot  <= n_slot;
                        r_full  <= !(r_fill < w_len);
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_state <= S_SQO;
                end
                S_SQO: begin
                    // The product now holds the square of the new sample.
                    r_sumsq <= r_sumsq + SQ_W'(w_rsp.prod);
                    if (r_full) begin
                        r_sum <= r_sum + SUM_W'(r_x) - SUM_W'(w_old);
                    end else begin
                        r_sum  <= r_sum + SUM_W'(r_x);
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    r_wp    <= (n_wp >= w_len) ? '0 : n_wp[PTR_W-1:0];
                    r_state <= S_SSUM;
                end
                S_SSUM: begin
                    if (r_full) begin
                        r_sumsq <= r_sumsq - SQ_W'(w_rsp.prod);
                    end
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_ssq   <= w_rsp.prod[NUM_W-1:0];
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_den   <= w_rsp.prod[DEN_W-1:0];
                    r_state <= S_MH;
                end
                S_MH: begin
                    r_num   <= w_rsp.prod[NUM_W-1:0];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num   <= r_num + {w_rsp.prod[NUM_W-21:0], 20'b0};
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_num   <= (r_num > r_ssq) ? (r_num - r_ssq) : '0;
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    // The quotient fits in 47 bits, so the top 16 dividend bits are already
                    // below the divisor and seed the partial remainder.
                    r_rem   <= DEN_W'(r_num[NUM_W-1:31]);
                    r_dq    <= {r_num[30:0], 16'b0};
                    r_cnt   <= 6'(NUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rsp.ge) begin
                        r_rem <= w_rsp.diff[DEN_W-1:0];
                    end else begin
                        r_rem <= {r_rem[DEN_W-2:0], r_dq[NUM_W-1]};
                    end
                    r_dq <= {r_dq[NUM_W-2:0], w_rsp.ge};
                    if (r_cnt == '0) begin
                        r_state <= S_SINIT;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_SINIT: begin
                    r_sx    <= {1'b0, r_dq};
                    r_sr    <= '0;
                    r_root  <= '0;
                    r_cnt   <= 6'(ROOT_W - 1);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_rsp.ge) begin
                        r_sr <= w_rsp.diff[ROOT_W:0];
                    end else begin
                        r_sr <= {r_sr[ROOT_W-2:0], r_sx[NUM_W:NUM_W-1]};
                    end
                    r_root <= {r_root[ROOT_W-2:0], w_rsp.ge};
                    r_sx   <= {r_sx[NUM_W-2:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_DONE: begin
                    // Wait until the output register is empty or is being emptied.
                    if (w_out_free) begin
                        r_out_data  <= r_root;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

[bench/sliding_window_std_dev_top_tb.sv]
`timescale 1ns / 1ps

module sliding_window_std_dev_top_tb;
    import swsd_pkg::*;

    // Cycles to let pass once the last result is in before the window length is rewritten.
    // It exceeds the block's time from acceptance to result, so this leaves a margin.
    localparam int SETTLE_CYCLES = 100;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data      = '0;

    // Percentages of idling on the sending and the receiving side; each test sets them.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Standard deviations still owed by the block, oldest first.
    logic [23:0] std_dev_due[$];
    int unsigned mismatch_count = 0;

    // The predictor's own copy of the window register and the window statistics.
    logic [8:0]  window_reg;
    t_sample     sample_hist [RING_DEPTH];
    int unsigned hist_wr;
    int unsigned hist_fill;
    longint      sum_acc;
    longint      square_acc;

    sliding_window_std_dev_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // The window statistics are cleared both by reset and by any write of the window length.
    function automatic void clear_window_stats();
        for (int k = 0; k < RING_DEPTH; k++) begin
            sample_hist[k] = '0;
        end
        hist_wr    = 0;
        hist_fill  = 0;
        sum_acc    = 0;
        square_acc = 0;
    endfunction

    // A window length of zero behaves as one, and anything above the ring depth saturates.
    function automatic int unsigned window_span();
        int unsigned span;
        span = window_reg;
        if (span == 0) begin
            span = 1;
        end
        if (span > RING_DEPTH) begin
            span = RING_DEPTH;
        end
        return span;
    endfunction

    // Bitwise integer square root, rounding down. The argument never exceeds 2^62,
    // so the trial squares stay inside 64 bits.
    function automatic bit [31:0] floor_sqrt(bit [63:0] v);
        bit [63:0] root;
        bit [63:0] probe;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= v) begin
                root = probe;
            end
        end
        return root[31:0];
    endfunction

    // Takes one accepted sample into the window and works out the standard deviation that
    // the block must return for it.
    function automatic logic [23:0] predict_std_dev(t_sample s);
        int unsigned span;
        int unsigned slot;
        longint      x;
        longint      oldest;
        bit [63:0]   m;
        bit [63:0]   sum_mag;
        bit [63:0]   sum_sq;
        bit [63:0]   num;
        bit [63:0]   variance;
        bit [31:0]   root;
        span = window_span();
        slot = (hist_wr >= span) ? 0 : hist_wr;
        x    = s;
        sum_acc    += x;
        square_acc += x * x;
        if (hist_fill < span) begin
            hist_fill++;
        end else begin
            // The window is full, so the oldest sample leaves it as the new one arrives.
            oldest      = sample_hist[slot];
            sum_acc    -= oldest;
            square_acc -= oldest * oldest;
        end
        sample_hist[slot] = s;
        hist_wr = (slot + 1 >= span) ? 0 : slot + 1;

        m       = hist_fill;
        sum_mag = (sum_acc < 0) ? 64'(-sum_acc) : 64'(sum_acc);
        sum_sq  = sum_mag * sum_mag;
        num     = m * 64'(square_acc);
        // A negative variance numerator is clamped to zero.
        num      = (num > sum_sq) ? num - sum_sq : 64'd0;
        variance = (num << 16) / (m * m);
        root     = floor_sqrt(variance);
        return root[23:0];
    endfunction

    // The receiver stalls at random, decided afresh at every falling edge.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result the block hands over is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (std_dev_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: std_dev %0d with nothing outstanding",
                             o_m_axis_tdata);
                end
            end else begin
                logic [23:0] want;
                want = std_dev_due.pop_front();
                if (o_m_axis_tdata !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("std_dev mismatch: expected %0d, got %0d",
                                 want, o_m_axis_tdata);
                    end
                end
            end
        end
    end

    // Offers one sample, after a random hold-off when the sender is meant to idle, and waits
    // for the edge that accepts it. Valid is left high so that the next item can follow at once.
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            // Hold-offs up to longer than one computation, so gaps land in every phase of it.
            repeat ($urandom_range(1, 120)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do @(posedge i_clk); while (!o_s_axis_tready);
        std_dev_due.push_back(predict_std_dev(s));
    endtask

    // Stops sending, waits for every outstanding result and lets the block settle.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (std_dev_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the window length while the block is idle. The unused upper data bits are random,
    // since the block must ignore them.
    task automatic write_window(input logic [8:0] len);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {7'($urandom), len};
        do @(posedge i_clk); while (!o_cfg_ready);
        window_reg = len;
        clear_window_stats();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sample generators: fully random, only the two extremes, values scattered closely
    // around a base, and a constant.
    function automatic t_sample pick_sample(int unsigned mode, t_sample base);
        case (mode)
            0: return t_sample'($urandom);
            1: return $urandom_range(1) ? t_sample'(16'h7FFF) : t_sample'(16'h8000);
            2: return base + t_sample'($urandom_range(16)) - t_sample'(8);
            default: return base;
        endcase
    endfunction

    // Uses the window length left by reset, sixteen. The extremes alternate to give the largest
    // spread, and the seventeenth item is the first to push an old sample out.
    task automatic test_reset_window();
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        for (int k = 0; k < 12; k++) begin
            send_sample((k % 2) ? 16'sh7FFF : 16'sh8000);
        end
    endtask

    // A window length of zero acts as one, so every result must be zero; one and two follow.
    task automatic test_short_windows();
        write_window(9'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        write_window(9'd1);
        send_sample(-16'sd1);
        send_sample(16'sh5A5A);
        write_window(9'd2);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd0);
    endtask

    // The largest value the field allows must saturate to the ring depth.
    task automatic test_oversized_window();
        write_window(9'd511);
        send_sample(16'sh1234);
        send_sample(-16'sh1234);
    endtask

    // Random traffic in runs: each run writes a fresh window length and then, unless the total runs
    // out first, sends more samples than the window holds, so that it fills and then slides. Most
    // windows are short; now and then the full ring depth, or a value that saturates to it, is chosen.
    task automatic test_random_traffic(input int unsigned n_items, input int unsigned send_pct,
                                       input int unsigned recv_pct);
        int unsigned sent;
        int unsigned pick;
        int unsigned run_len;
        int unsigned mode;
        logic [8:0]  len;
        t_sample     base;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                len = 9'($urandom_range(1, 24));
            end else if (pick < 73) begin
                len = 9'd0;
            end else if (pick < 88) begin
                len = 9'($urandom_range(25, 255));
            end else if (pick < 95) begin
                len = 9'd256;
            end else begin
                len = 9'($urandom_range(257, 511));
            end
            write_window(len);
            if (window_span() >= 64) begin
                run_len = window_span() + $urandom_range(8, 40);
            end else begin
                run_len = $urandom_range(window_span() + 2, 3 * window_span() + 20);
            end
            if (run_len > n_items - sent) begin
                run_len = n_items - sent;
            end
            pick = $urandom_range(99);
            mode = (pick < 40) ? 0 : (pick < 60) ? 1 : (pick < 85) ? 2 : 3;
            base = t_sample'($urandom);
            for (int k = 0; k < run_len; k++) begin
                // An odd item of another kind now and then keeps runs from being uniform.
                send_sample(pick_sample(($urandom_range(9) == 0) ? 0 : mode, base));
            end
            sent += run_len;
        end
    endtask

    initial begin
        window_reg = WIN_RESET[8:0];
        clear_window_stats();
        send_idle_pct = 24;
        recv_idle_pct = 54;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_short_windows();
        test_oversized_window();
        test_random_traffic(650, 24, 54);
        test_random_traffic(650, 54, 24);
        test_random_traffic(650, 0, 0);

        drain_results();
        if (mismatch_count == 0) begin
            $display("sliding_window_std_dev_top_tb: PASS");
        end else begin
            $display("sliding_window_std_dev_top_tb: FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("sliding_window_std_dev_top_tb: FAIL");
        $finish;
    end

endmodule

[sliding_window_std_dev_top.f]
hdl/swsd_pkg.sv
hdl/swsd_ring.sv
hdl/swsd_alu.sv
hdl/sliding_window_std_dev_top.sv
bench/sliding_window_std_dev_top_tb.sv
